// File: sv/chd_pkg.sv
// shared types and constants of the canonical huffman decoder
// no dependencies; every other file of the block imports this package
`default_nettype none

package chd_pkg;

  localparam int ACT_W  = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;
  localparam int KIND_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BIT   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } act_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGNED   = 2'd0,
    KIND_DECODED    = 2'd1,
    KIND_REJECTED   = 2'd2,
    KIND_BAD_STREAM = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic emit;
  } chd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic out_free;
  } chd_sts_t;

endpackage

`default_nettype wire

// File: sv/chd_in_if.sv
// input channel of the canonical huffman decoder: valid/ready plus one item
// depends on chd_pkg
`default_nettype none

interface chd_in_if import chd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SYM_W-1:0]  new_symbol;
  logic [LEN_W-1:0]  new_length;
  logic              code_bit;

  modport source (output valid, action, new_symbol, new_length, code_bit, input ready);
  modport sink   (input valid, action, new_symbol, new_length, code_bit, output ready);
endinterface

`default_nettype wire

// File: sv/chd_out_if.sv
// result channel of the canonical huffman decoder: valid/ready plus one result
// depends on chd_pkg
`default_nettype none

interface chd_out_if import chd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  out_symbol;
  logic [CODE_W-1:0] out_code;
  logic [LEN_W-1:0]  out_length;

  modport source (output valid, kind, out_symbol, out_code, out_length, input ready);
  modport sink   (input valid, kind, out_symbol, out_code, out_length, output ready);
endinterface

`default_nettype wire

// File: sv/canonical_huffman_decoder.sv
// Canonical huffman decoder. Items arrive on in_ch: load a (symbol, length) entry, feed one
// code bit, or clear the table. Each item is captured and then looked up in the
// per-length tables in the next cycle; an item that yields a result then passes to the
// output register, and waits while that register is still held by an untaken result. A
// decoded symbol comes from a registered read of the symbol store made during the
// lookup. Results leave through an output register on out_ch, so the next item is
// accepted while a result still waits. The symbol store needs no clearing pass after
// reset; only slots filled since the last clear are ever read.
// depends on chd_pkg, chd_in_if, chd_out_if, chd_ctrl, chd_dpath
`default_nettype none

module canonical_huffman_decoder import chd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_SLOTS = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  chd_in_if.sink    in_ch,
  chd_out_if.source out_ch
);

  chd_cmd_t cmd;
  chd_sts_t sts;

  chd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chd_dpath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_SLOTS (SYMBOL_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_new_symbol (in_ch.new_symbol),
    .in_new_length (in_ch.new_length),
    .in_code_bit   (in_ch.code_bit),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.kind),
    .out_symbol    (out_ch.out_symbol),
    .out_code      (out_ch.out_code),
    .out_length    (out_ch.out_length)
  );

  // a result is only moved into the output register when that register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote an untaken output transaction");

  // every accepted transaction is processed in the following cycle
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd.exec)
    else $error("accepted transaction was not processed");

  // no new transaction while one is in flight
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.emit) |-> !in_ch.ready)
    else $error("input ready while a transaction is in flight");

  // an emitted result shows up as valid on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

endmodule

`default_nettype wire

// File: sv/chd_ctrl.sv
// sequencer of the canonical huffman decoder: capture, table step, result hand-off
// depends on chd_pkg
`default_nettype none

module chd_ctrl import chd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire chd_sts_t sts,
  output chd_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.has_result ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // wait here while the output register still holds an untaken result
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/chd_dpath.sv
// datapath of the canonical huffman decoder: per-length tables, code
// assignment, bit matcher, symbol store and output register; depends on chd_pkg
`default_nettype none

module chd_dpath import chd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_SLOTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire chd_cmd_t          cmd,
  output chd_sts_t               sts,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [SYM_W-1:0]  in_new_symbol,
  input  wire logic [LEN_W-1:0]  in_new_length,
  input  wire logic              in_code_bit,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      out_kind,
  output logic [SYM_W-1:0]       out_symbol,
  output logic [CODE_W-1:0]      out_code,
  output logic [LEN_W-1:0]       out_length
);

  localparam int CW = MAX_CODE_LEN;
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int IW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int SW = $clog2(SYMBOL_SLOTS);
  localparam int NW = $clog2(SYMBOL_SLOTS + 1);
  localparam int DW = (CW > NW) ? CW : NW;

  // captured item
  act_t             act_r;
  logic [SYM_W-1:0] sym_r;
  logic [LEN_W-1:0] len_r;
  logic             bit_r;

  // per-length tables; only count needs clearing, the others are read behind it
  logic [NW-1:0] cnt_r        [MAX_CODE_LEN];
  logic [CW-1:0] first_code_r [MAX_CODE_LEN];
  logic [SW-1:0] first_slot_r [MAX_CODE_LEN];

  logic [SYM_W-1:0] sym_mem [SYMBOL_SLOTS];
  logic [SYM_W-1:0] rd_sym_r;

  logic [NW-1:0] entries_r;
  logic [CW-1:0] prev_code_r;
  logic [LW-1:0] prev_len_r;
  logic [CW-1:0] pend_code_r;
  logic [LW-1:0] pend_len_r;

  // result waiting for the output register
  kind_t             res_kind_r;
  logic [SYM_W-1:0]  res_sym_r;
  logic [CODE_W-1:0] res_code_r;
  logic [LEN_W-1:0]  res_len_r;
  logic              res_from_mem_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [SYM_W-1:0]  out_symbol_r;
  logic [CODE_W-1:0] out_code_r;
  logic [LEN_W-1:0]  out_length_r;

  logic          is_load, is_bit, is_clear;
  logic [5:0]    len6, prev6, shamt;
  logic [CW:0]   next_code;
  logic          ovf, ld_bad, ld_ok;
  logic [CW-1:0] ld_code;
  logic [IW-1:0] ld_idx, bit_idx, tbl_idx;
  logic [NW-1:0] cnt_rd;
  logic [CW-1:0] fc_rd;
  logic [SW-1:0] fs_rd;
  logic [CW-1:0] p_code;
  logic [LW-1:0] p_len;
  logic [DW-1:0] off;
  logic [SW-1:0] slot;
  logic          matched, bad_stream, rd_en;

  assign is_load  = cmd.exec && (act_r == ACT_LOAD);
  assign is_bit   = cmd.exec && (act_r == ACT_BIT);
  assign is_clear = cmd.exec && (act_r == ACT_CLEAR);

  // code assignment
  assign len6      = 6'(len_r);
  assign prev6     = 6'(prev_len_r);
  assign shamt     = len6 - prev6;
  assign next_code = {1'b0, prev_code_r} + (CW+1)'(1);
  assign ovf       = (next_code >> prev_len_r) != '0;
  assign ld_code   = (entries_r == '0) ? '0 : (next_code[CW-1:0] << shamt);
  assign ld_bad    = (sym_r == '0) || (len_r == '0) || (len6 > 6'(MAX_CODE_LEN)) ||
                     (entries_r >= NW'(SYMBOL_SLOTS)) ||
                     ((entries_r != '0) && ((len6 < prev6) || ovf));
  assign ld_ok     = is_load && !ld_bad;
  assign ld_idx    = IW'(len_r - LEN_W'(1));

  // bit matcher: new pending length minus one is the old pending length
  assign p_code  = (pend_code_r << 1) | CW'(bit_r);
  assign p_len   = pend_len_r + LW'(1);
  assign bit_idx = IW'(pend_len_r);
  assign tbl_idx = (act_r == ACT_LOAD) ? ld_idx : bit_idx;
  assign cnt_rd  = cnt_r[tbl_idx];
  assign fc_rd   = first_code_r[tbl_idx];
  assign fs_rd   = first_slot_r[tbl_idx];

  assign off        = DW'(p_code) - DW'(fc_rd);
  assign matched    = (cnt_rd != '0) && (p_code >= fc_rd) && (off < DW'(cnt_rd));
  assign slot       = fs_rd + SW'(off);
  assign bad_stream = !matched && ((p_len >= prev_len_r) || (p_len >= LW'(MAX_CODE_LEN)));
  assign rd_en      = is_bit && matched;

  assign sts.has_result = (act_r == ACT_LOAD) ||
                          ((act_r == ACT_BIT) && (matched || bad_stream));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= act_t'(in_action);
      sym_r <= in_new_symbol;
      len_r <= in_new_length;
      bit_r <= in_code_bit;
    end
  end

  // symbol store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (ld_ok) begin
      sym_mem[entries_r[SW-1:0]] <= sym_r;
    end else if (rd_en) begin
      rd_sym_r <= sym_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ok && (cnt_rd == '0)) begin
      first_code_r[ld_idx] <= ld_code;
      first_slot_r[ld_idx] <= entries_r[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || is_clear) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        cnt_r[i] <= '0;
      end
      entries_r   <= '0;
      prev_code_r <= '0;
      prev_len_r  <= '0;
      pend_code_r <= '0;
      pend_len_r  <= '0;
    end else begin
      if (ld_ok) begin
        cnt_r[ld_idx] <= cnt_rd + NW'(1);
        entries_r     <= entries_r + NW'(1);
        prev_code_r   <= ld_code;
        prev_len_r    <= LW'(len_r);
      end
      if (is_bit) begin
        if (matched || bad_stream) begin
          pend_code_r <= '0;
          pend_len_r  <= '0;
        end else begin
          pend_code_r <= p_code;
          pend_len_r  <= p_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_load) begin
      res_kind_r     <= ld_bad ? KIND_REJECTED : KIND_ASSIGNED;
      res_sym_r      <= sym_r;
      res_code_r     <= ld_bad ? '0 : CODE_W'(ld_code);
      res_len_r      <= len_r;
      res_from_mem_r <= 1'b0;
    end else if (is_bit) begin
      res_kind_r     <= matched ? KIND_DECODED : KIND_BAD_STREAM;
      res_sym_r      <= '0;
      res_code_r     <= CODE_W'(p_code);
      res_len_r      <= LEN_W'(p_len);
      res_from_mem_r <= matched;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= res_kind_r;
      out_symbol_r <= res_from_mem_r ? rd_sym_r : res_sym_r;
      out_code_r   <= res_code_r;
      out_length_r <= res_len_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_symbol = out_symbol_r;
  assign out_code   = out_code_r;
  assign out_length = out_length_r;

endmodule

`default_nettype wire
